FILE: hw/rtl/sepq_pkg.sv
package sepq_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_PEEK   = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(CAPACITY);

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] event_time;
        logic [15:0] event_id;
    } t_request;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        head_time;
        logic [15:0]        head_id;
        logic [COUNT_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic [31:0] ev_time;
        logic [15:0] ev_id;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry key;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/sepq_cell.sv
module sepq_cell (
    input  logic               i_clk,
    input  sepq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  logic               i_left_gt,
    input  sepq_pkg::t_entry   i_left_entry,
    input  sepq_pkg::t_entry   i_right_entry,
    output sepq_pkg::t_entry   o_entry,
    output logic               o_gt
);
    import sepq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // An empty cell orders after any key, so the first free cell always fills on an insert.
    assign o_gt = !i_occ || ({r_entry.ev_time, r_entry.ev_id} >
                             {i_ctl.key.ev_time, i_ctl.key.ev_id});
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && o_gt) begin
            n_entry = i_left_gt ? i_left_entry : i_ctl.key;
        end else if (i_ctl.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: hw/rtl/sorted_event_priority_queue.sv
// Sorted priority queue of up to sixteen events, ordered by time and then by id.
// Each request (insert, peek or pop) is taken when start is high and busy is
// low; busy then stays high while the row of cells compares every held entry
// with the request at once and shifts in place, and the result appears on the
// following cycle with o_strobe high for exactly one cycle. No new request is
// taken while busy is high. The receiver cannot stall the result, so it must
// capture it in the strobe cycle. An insert into a full queue returns the full
// status, and a peek or pop of an empty queue returns the empty status; head
// fields are zero unless a peek succeeds.
module sorted_event_priority_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  sepq_pkg::t_request i_req,
    output logic               busy,
    output logic               o_strobe,
    output sepq_pkg::t_result  o_result
);
    import sepq_pkg::*;

    logic               r_busy;
    t_request           r_req;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_strobe;
    t_result            r_result;
    t_result            n_result;
    t_cell_ctl          cell_ctl;
    t_entry             entry   [CAPACITY];
    logic               gt      [CAPACITY];

    assign cell_ctl.ins = r_busy && (r_req.op == OP_INSERT) && (r_count != COUNT_FULL);
    assign cell_ctl.pop = r_busy && (r_req.op == OP_POP) && (r_count != '0);
    assign cell_ctl.key.ev_time = r_req.event_time;
    assign cell_ctl.key.ev_id   = r_req.event_id;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic   left_gt;
            t_entry left_entry;
            t_entry right_entry;
            if (gi == 0) begin : g_first
                assign left_gt    = 1'b0;
                assign left_entry = entry[gi];
            end else begin : g_mid
                assign left_gt    = gt[gi-1];
                assign left_entry = entry[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_entry = entry[gi];
            end else begin : g_inner
                assign right_entry = entry[gi+1];
            end
            sepq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (cell_ctl),
                .i_occ         (COUNT_W'(gi) < r_count),
                .i_left_gt     (left_gt),
                .i_left_entry  (left_entry),
                .i_right_entry (right_entry),
                .o_entry       (entry[gi]),
                .o_gt          (gt[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_result = '0;
        case (r_req.op)
            OP_INSERT: begin
                if (r_count == COUNT_FULL) begin
                    n_result.status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_PEEK: begin
                if (r_count == '0) begin
                    n_result.status = ST_EMPTY;
                end else begin
                    n_result.head_time = entry[0].ev_time;
                    n_result.head_id   = entry[0].ev_id;
                end
            end
            OP_POP: begin
                if (r_count == '0) begin
                    n_result.status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_result.status = ST_OK;
            end
        endcase
        n_result.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_strobe <= r_busy;
            if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end else if (start) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_req <= i_req;
        end
        if (r_busy) begin
            r_result <= n_result;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

FILE: hw/rtl/sepq_chk.sv
module sepq_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input sepq_pkg::t_request i_req,
    input logic               busy,
    input logic               o_strobe,
    input sepq_pkg::t_result  o_result
);
    import sepq_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("Accepted request did not raise busy.");

    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe && !busy)
        else $error("Busy cycle was not followed by a result.");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("Result strobe while busy.");

    a_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status != ST_OK |->
            o_result.head_time == '0 && o_result.head_id == '0)
        else $error("Head fields nonzero on a failed request.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status == ST_FULL |-> o_result.count == COUNT_FULL)
        else $error("Full status with a count below capacity.");

endmodule

bind sorted_event_priority_queue sepq_chk u_sepq_chk (.*);
